// ----- hdl/rtp_jrb_pkg.sv -----
// Shared types and constants for the RTP jitter reorder buffer.
package rtp_jrb_pkg;

    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int PT_W       = 7;
    localparam int DEPTH_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int OFFSET_W   = 7;
    localparam int LEN_W      = 11;
    localparam int NOUT_W     = 5;

    localparam int MAX_OUT     = 16;
    localparam int HDR_BYTES   = 12;
    localparam int RTP_VERSION = 2;

    // item opcodes
    localparam logic [OP_W-1:0] OP_ARRIVE  = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_VER   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd6;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FRAME  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DEPTH = 2'd1;

    // per-cell update select
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_LOAD  = 2'd1;
    localparam logic [1:0] CELL_LEFT  = 2'd2;
    localparam logic [1:0] CELL_RIGHT = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      header_byte0;
        logic [7:0]      header_byte1;
        logic [15:0]     sequence_req;
        logic [31:0]     timestamp;
        logic [LEN_W-1:0] packet_length;
        logic [15:0]     payload_handle;
    } t_item;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [15:0]         out_sequence;
        logic                out_marker;
        logic [31:0]         out_timestamp;
        logic [15:0]         out_handle;
        logic [OFFSET_W-1:0] payload_offset;
        logic [LEN_W-1:0]    payload_length;
        logic                last;
    } t_result;

    typedef struct packed {
        logic [15:0]         seq;
        logic [31:0]         ts;
        logic                marker;
        logic [OFFSET_W-1:0] offset;
        logic [LEN_W-1:0]    plen;
        logic [15:0]         handle;
    } t_entry;

endpackage

// ----- hdl/rtp_jrb_cell.sv -----
// One slot of the sorted entry chain: holds, loads, or takes a neighbor's entry.
module rtp_jrb_cell (
    input  logic                  i_clk,
    input  logic [1:0]            i_op,
    input  rtp_jrb_pkg::t_entry   i_new,
    input  rtp_jrb_pkg::t_entry   i_left,
    input  rtp_jrb_pkg::t_entry   i_right,
    output rtp_jrb_pkg::t_entry   o_entry
);

    rtp_jrb_pkg::t_entry r_entry;
    rtp_jrb_pkg::t_entry n_entry;

    always_comb begin
        unique case (i_op)
            rtp_jrb_pkg::CELL_LOAD:  n_entry = i_new;
            rtp_jrb_pkg::CELL_LEFT:  n_entry = i_left;
            rtp_jrb_pkg::CELL_RIGHT: n_entry = i_right;
            default:                 n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ----- hdl/rtp_jitter_reorder_buffer.sv -----
// Top level of the RTP jitter reorder buffer: control sequencer and cell chain.
// A rejected packet or a flush gives its word in the cycle after start; a release that pops
// nothing gives its word from S_POP; any other packet runs S_SEARCH, one search probe a cycle
// until the window is empty, then compares and inserts in S_PLACE.
// Release emits one frame word per cycle, up to 16 words.
// One item at a time: busy stays high until its last word is issued; results cannot be stalled.
// Synchronous active-low reset empties the buffer and loads payload type 0, release depth 8.
module rtp_jitter_reorder_buffer #(
    parameter int CAPACITY = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  rtp_jrb_pkg::t_item                     i_item,
    output logic                                   o_strobe,
    output rtp_jrb_pkg::t_result                   o_result,
    input  logic                                   i_cfg_we,
    input  logic [rtp_jrb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rtp_jrb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > rtp_jrb_pkg::DEPTH_W) ? CNT_W : rtp_jrb_pkg::DEPTH_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_PLACE  = 2'd2;
    localparam logic [1:0] S_POP    = 2'd3;

    logic [1:0]                            r_state, n_state;
    logic [CNT_W-1:0]                      r_count, n_count;
    logic [CNT_W-1:0]                      r_first, n_first;
    logic [CNT_W-1:0]                      r_span, n_span;
    logic [rtp_jrb_pkg::NOUT_W-1:0]        r_nout, n_nout;
    rtp_jrb_pkg::t_entry                   r_new, n_new;
    logic [rtp_jrb_pkg::PT_W-1:0]          r_pt;
    logic [rtp_jrb_pkg::DEPTH_W-1:0]       r_depth;
    logic                                  r_strobe, n_strobe;
    rtp_jrb_pkg::t_result                  r_result, n_result;

    rtp_jrb_pkg::t_entry                   w_cell  [CAPACITY];
    rtp_jrb_pkg::t_entry                   w_left  [CAPACITY];
    rtp_jrb_pkg::t_entry                   w_right [CAPACITY];
    logic [1:0]                            w_op    [CAPACITY];

    logic [rtp_jrb_pkg::OFFSET_W-1:0]      w_offset;
    logic [CNT_W-1:0]                      w_half;
    logic [CNT_W-1:0]                      w_mid;
    logic [IDX_W-1:0]                      w_rd_idx;
    logic [15:0]                           w_rd_seq;
    logic [15:0]                           w_diff;
    logic [CNT_W-1:0]                      w_cnt_m1;
    logic                                  w_pop_ok;
    logic                                  w_more;

    function automatic rtp_jrb_pkg::t_result status_word(
        input logic [rtp_jrb_pkg::STATUS_W-1:0] st
    );
        rtp_jrb_pkg::t_result res;
        res        = '0;
        res.kind   = rtp_jrb_pkg::KIND_STATUS;
        res.status = st;
        res.last   = 1'b1;
        return res;
    endfunction

    // ---------------- cell chain ----------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_lo
            assign w_left[g] = r_new;
        end else begin : g_lo
            assign w_left[g] = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_hi
            assign w_right[g] = r_new;
        end else begin : g_hi
            assign w_right[g] = w_cell[g+1];
        end
        rtp_jrb_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op[g]),
            .i_new   (r_new),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_entry (w_cell[g])
        );
    end

    // ---------------- datapath helpers ----------------
    assign w_offset = rtp_jrb_pkg::OFFSET_W'(rtp_jrb_pkg::HDR_BYTES)
                    + {1'b0, i_item.header_byte0[3:0], 2'b00};
    assign w_half   = r_span >> 1;
    assign w_mid    = r_first + w_half;
    // one read port: probe address while searching, insert point otherwise
    assign w_rd_idx = (r_state == S_SEARCH) ? w_mid[IDX_W-1:0] : r_first[IDX_W-1:0];
    assign w_rd_seq = w_cell[w_rd_idx].seq;
    assign w_diff   = w_rd_seq - r_new.seq;
    assign w_cnt_m1 = r_count - CNT_W'(1);
    assign w_pop_ok = (r_count != '0) && (CMP_W'(r_count) >= CMP_W'(r_depth));
    assign w_more   = (w_cnt_m1 != '0) && (CMP_W'(w_cnt_m1) >= CMP_W'(r_depth));

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_first  = r_first;
        n_span   = r_span;
        n_nout   = r_nout;
        n_new    = r_new;
        n_strobe = 1'b0;
        n_result = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_op[i] = rtp_jrb_pkg::CELL_HOLD;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_new.seq    = i_item.sequence_req;
                    n_new.ts     = i_item.timestamp;
                    n_new.marker = i_item.header_byte1[7];
                    n_new.offset = w_offset;
                    n_new.plen   = i_item.packet_length - rtp_jrb_pkg::LEN_W'(w_offset);
                    n_new.handle = i_item.payload_handle;
                    case (i_item.op)
                        rtp_jrb_pkg::OP_ARRIVE: begin
                            if (i_item.header_byte0[7:6] != 2'(rtp_jrb_pkg::RTP_VERSION)) begin
                                n_strobe = 1'b1;
                                n_result = status_word(rtp_jrb_pkg::ST_BAD_VER);
                            end else if (i_item.header_byte1[6:0] != r_pt) begin
                                n_strobe = 1'b1;
                                n_result = status_word(rtp_jrb_pkg::ST_BAD_TYPE);
                            end else if (i_item.packet_length
                                         < rtp_jrb_pkg::LEN_W'(w_offset)) begin
                                n_strobe = 1'b1;
                                n_result = status_word(rtp_jrb_pkg::ST_SHORT);
                            end else begin
                                n_first = '0;
                                n_span  = r_count;
                                n_state = S_SEARCH;
                            end
                        end
                        rtp_jrb_pkg::OP_RELEASE: begin
                            n_nout  = '0;
                            n_state = S_POP;
                        end
                        rtp_jrb_pkg::OP_FLUSH: begin
                            n_count  = '0;
                            n_strobe = 1'b1;
                            n_result = status_word(rtp_jrb_pkg::ST_OK);
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                // lower-bound probe with wrap-around sequence order
                if (r_span == '0) begin
                    n_state = S_PLACE;
                end else if (w_diff[15]) begin
                    n_first = w_mid + CNT_W'(1);
                    n_span  = r_span - w_half - CNT_W'(1);
                end else begin
                    n_span  = w_half;
                end
            end

            S_PLACE: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if ((r_first < r_count) && (w_rd_seq == r_new.seq)) begin
                    n_result = status_word(rtp_jrb_pkg::ST_DUPLICATE);
                end else if (r_count >= CNT_W'(CAPACITY)) begin
                    n_result = status_word(rtp_jrb_pkg::ST_FULL);
                end else begin
                    n_result = status_word(rtp_jrb_pkg::ST_OK);
                    n_count  = r_count + CNT_W'(1);
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (CNT_W'(i) == r_first) begin
                            w_op[i] = rtp_jrb_pkg::CELL_LOAD;
                        end else if (CNT_W'(i) > r_first) begin
                            w_op[i] = rtp_jrb_pkg::CELL_LEFT;
                        end
                    end
                end
            end

            S_POP: begin
                n_strobe = 1'b1;
                if (w_pop_ok) begin
                    n_result.kind           = rtp_jrb_pkg::KIND_FRAME;
                    n_result.status         = rtp_jrb_pkg::ST_OK;
                    n_result.out_sequence   = w_cell[0].seq;
                    n_result.out_marker     = w_cell[0].marker;
                    n_result.out_timestamp  = w_cell[0].ts;
                    n_result.out_handle     = w_cell[0].handle;
                    n_result.payload_offset = w_cell[0].offset;
                    n_result.payload_length = w_cell[0].plen;
                    n_result.last           = (r_nout == rtp_jrb_pkg::NOUT_W'(
                                                   rtp_jrb_pkg::MAX_OUT - 1)) || !w_more;
                    n_count = w_cnt_m1;
                    n_nout  = r_nout + rtp_jrb_pkg::NOUT_W'(1);
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        w_op[i] = rtp_jrb_pkg::CELL_RIGHT;
                    end
                    if (n_result.last) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    // only reached when nothing was popped
                    n_result = status_word(rtp_jrb_pkg::ST_NONE);
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_first  <= '0;
            r_span   <= '0;
            r_nout   <= '0;
            r_strobe <= 1'b0;
            r_pt     <= '0;
            r_depth  <= rtp_jrb_pkg::DEPTH_W'(8);
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_first  <= n_first;
            r_span   <= n_span;
            r_nout   <= n_nout;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rtp_jrb_pkg::CFG_PAYLOAD_TYPE:  r_pt    <= i_cfg_data[rtp_jrb_pkg::PT_W-1:0];
                    rtp_jrb_pkg::CFG_RELEASE_DEPTH: r_depth <= i_cfg_data[rtp_jrb_pkg::DEPTH_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_new    <= n_new;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // ---------------- assertions ----------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |->
            (({1'b0, r_first} + {1'b0, r_span}) <= {1'b0, r_count}))
        else $error("search window outside stored entries");

    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.kind == rtp_jrb_pkg::KIND_FRAME) |->
            (o_result.status == rtp_jrb_pkg::ST_OK))
        else $error("frame word with nonzero status");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.kind == rtp_jrb_pkg::KIND_STATUS) |-> o_result.last)
        else $error("status word without last mark");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !o_busy)
        else $error("busy after final word of an item");

endmodule
